/* sv/rvdec_pkg.sv */
// Shared types, opcode, format and mnemonic codes for the RV32I subset decoder.
package rvdec_pkg;

	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;

	localparam logic [1:0] FMT_R = 2'd0;
	localparam logic [1:0] FMT_I = 2'd1;
	localparam logic [1:0] FMT_S = 2'd2;
	localparam logic [1:0] FMT_B = 2'd3;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR  = 3'd5;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [4:0] MN_ADD  = 5'd0;
	localparam logic [4:0] MN_SUB  = 5'd1;
	localparam logic [4:0] MN_XOR  = 5'd2;
	localparam logic [4:0] MN_OR   = 5'd3;
	localparam logic [4:0] MN_AND  = 5'd4;
	localparam logic [4:0] MN_SLL  = 5'd5;
	localparam logic [4:0] MN_SRL  = 5'd6;
	localparam logic [4:0] MN_SRA  = 5'd7;
	localparam logic [4:0] MN_ADDI = 5'd8;
	localparam logic [4:0] MN_XORI = 5'd9;
	localparam logic [4:0] MN_ORI  = 5'd10;
	localparam logic [4:0] MN_ANDI = 5'd11;
	localparam logic [4:0] MN_SLLI = 5'd12;
	localparam logic [4:0] MN_SRLI = 5'd13;
	localparam logic [4:0] MN_SRAI = 5'd14;
	localparam logic [4:0] MN_LW   = 5'd15;
	localparam logic [4:0] MN_SW   = 5'd16;
	localparam logic [4:0] MN_BEQ  = 5'd17;

	typedef struct packed {
		logic [6:0]  major_opcode;
		logic [4:0]  dest_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic [2:0]  func3_field;
		logic [6:0]  func7_field;
		logic [12:0] immediate;
		logic [1:0]  format_code;
		logic [4:0]  mnemonic_code;
		logic        illegal;
	} decode_result_t;

endpackage

/* sv/rvdec_decode.sv */
// Combinational field extraction and mnemonic lookup for one instruction word.
module rvdec_decode (
	input  logic [31:0]              instr,
	output rvdec_pkg::decode_result_t result
);
	import rvdec_pkg::*;

	logic [6:0] opc;
	logic [4:0] f_rd;
	logic [4:0] f_rs1;
	logic [4:0] f_rs2;
	logic [2:0] f3;
	logic [6:0] f7;
	logic       hit;
	logic [4:0] mn;

	assign opc   = instr[6:0];
	assign f_rd  = instr[11:7];
	assign f_rs1 = instr[19:15];
	assign f_rs2 = instr[24:20];
	assign f3    = instr[14:12];
	assign f7    = instr[31:25];

	always_comb begin
		result              = '0;
		result.major_opcode = opc;
		hit                 = 1'b0;
		mn                  = MN_ADD;
		case (opc)
			OPC_OP: begin
				result.format_code = FMT_R;
				result.dest_reg    = f_rd;
				result.src1_reg    = f_rs1;
				result.src2_reg    = f_rs2;
				result.func3_field = f3;
				result.func7_field = f7;
				if (f7 == F7_BASE) begin
					hit = 1'b1;
					case (f3)
						F3_ADD:  mn = MN_ADD;
						F3_SLL:  mn = MN_SLL;
						F3_XOR:  mn = MN_XOR;
						F3_SR:   mn = MN_SRL;
						F3_OR:   mn = MN_OR;
						F3_AND:  mn = MN_AND;
						default: hit = 1'b0;
					endcase
				end else if (f7 == F7_ALT) begin
					hit = 1'b1;
					case (f3)
						F3_ADD:  mn = MN_SUB;
						F3_SR:   mn = MN_SRA;
						default: hit = 1'b0;
					endcase
				end
			end
			OPC_OPIMM: begin
				result.format_code = FMT_I;
				result.dest_reg    = f_rd;
				result.src1_reg    = f_rs1;
				result.func3_field = f3;
				result.immediate   = {1'b0, instr[31:20]};
				if (f3 inside {F3_SLL, F3_SR}) begin
					result.func7_field = f7;
				end
				hit = 1'b1;
				case (f3)
					F3_ADD: mn = MN_ADDI;
					F3_XOR: mn = MN_XORI;
					F3_OR:  mn = MN_ORI;
					F3_AND: mn = MN_ANDI;
					F3_SLL: begin
						mn  = MN_SLLI;
						hit = (f7 == F7_BASE);
					end
					F3_SR: begin
						mn  = (f7 == F7_ALT) ? MN_SRAI : MN_SRLI;
						hit = (f7 == F7_BASE) || (f7 == F7_ALT);
					end
					default: hit = 1'b0;
				endcase
			end
			OPC_LOAD: begin
				result.format_code = FMT_I;
				result.dest_reg    = f_rd;
				result.src1_reg    = f_rs1;
				result.func3_field = f3;
				result.immediate   = {1'b0, instr[31:20]};
				mn                 = MN_LW;
				hit                = (f3 == F3_WORD);
			end
			OPC_STORE: begin
				result.format_code = FMT_S;
				result.src1_reg    = f_rs1;
				result.src2_reg    = f_rs2;
				result.func3_field = f3;
				result.immediate   = {1'b0, instr[31:25], instr[11:7]};
				mn                 = MN_SW;
				hit                = (f3 == F3_WORD);
			end
			OPC_BRANCH: begin
				result.format_code = FMT_B;
				result.src1_reg    = f_rs1;
				result.src2_reg    = f_rs2;
				result.func3_field = f3;
				result.immediate   = {instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
				mn                 = MN_BEQ;
				hit                = (f3 == F3_ADD);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		result.mnemonic_code = hit ? mn : MN_ADD;
		result.illegal       = !hit;
	end

endmodule

/* sv/rv32i_subset_instruction_decoder_core.sv */
// Top level of the RV32I subset decoder: input register, decode, result register.
// An accepted word is held in the input register and decoded combinationally; the decode
// is then held in the result register, which drives result_valid.
// Throughput: one instruction per cycle while result_ready is high, set by the two-register
// pipeline with ready propagated back from the result register.
// Reset: arst_n clears both stage valid bits at once; payload is not reset.
module rv32i_subset_instruction_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instruction_word,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [6:0]  major_opcode,
	output logic [4:0]  dest_reg,
	output logic [4:0]  src1_reg,
	output logic [4:0]  src2_reg,
	output logic [2:0]  func3_field,
	output logic [6:0]  func7_field,
	output logic [12:0] immediate,
	output logic [1:0]  format_code,
	output logic [4:0]  mnemonic_code,
	output logic        illegal
);
	import rvdec_pkg::*;

	logic           valid_s1;
	logic [31:0]    instr_s1;
	logic           valid_s2;
	decode_result_t result_s2;
	decode_result_t dec;
	logic           adv_s2;
	logic           adv_s1;

	assign adv_s2      = !valid_s2 || result_ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign instr_ready = adv_s1;

	rvdec_decode u_decode (
		.instr  (instr_s1),
		.result (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= instr_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && instr_valid) begin
			instr_s1 <= instruction_word;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= dec;
		end
	end

	assign result_valid  = valid_s2;
	assign major_opcode  = result_s2.major_opcode;
	assign dest_reg      = result_s2.dest_reg;
	assign src1_reg      = result_s2.src1_reg;
	assign src2_reg      = result_s2.src2_reg;
	assign func3_field   = result_s2.func3_field;
	assign func7_field   = result_s2.func7_field;
	assign immediate     = result_s2.immediate;
	assign format_code   = result_s2.format_code;
	assign mnemonic_code = result_s2.mnemonic_code;
	assign illegal       = result_s2.illegal;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_ready |=> valid_s1)
		else $error("accepted transaction did not reach the input register");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("decoded transaction did not reach the result register");

	a_illegal_no_mnemonic: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && illegal |-> mnemonic_code == MN_ADD)
		else $error("illegal result carries a mnemonic");

	a_i_format_no_rs2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !illegal && format_code == FMT_I |-> src2_reg == 5'd0)
		else $error("I format result carries a second source register");

endmodule

/* bench/rv32i_subset_instruction_decoder_core_tb.sv */
// Testbench for the RV32I subset decoder: directed table and random words checked per field.
`timescale 1ns / 1ps

module rv32i_subset_instruction_decoder_core_tb;
	import rvdec_pkg::*;

	typedef struct packed {
		logic [31:0]    word;
		logic           typed;
		decode_result_t golden;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        instr_valid;
	logic        instr_ready;
	logic [31:0] instruction_word;
	logic        result_valid;
	logic        result_ready;
	logic [6:0]  major_opcode;
	logic [4:0]  dest_reg;
	logic [4:0]  src1_reg;
	logic [4:0]  src2_reg;
	logic [2:0]  func3_field;
	logic [6:0]  func7_field;
	logic [12:0] immediate;
	logic [1:0]  format_code;
	logic [4:0]  mnemonic_code;
	logic        illegal;

	decode_result_t expected_decodes[$];
	decode_result_t pending_decode;
	stim_row_t      stim_table[$];
	int             error_count = 0;
	int             quiet_cycles = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;

	rv32i_subset_instruction_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_ready(instr_ready),
		.instruction_word(instruction_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.major_opcode(major_opcode),
		.dest_reg(dest_reg),
		.src1_reg(src1_reg),
		.src2_reg(src2_reg),
		.func3_field(func3_field),
		.func7_field(func7_field),
		.immediate(immediate),
		.format_code(format_code),
		.mnemonic_code(mnemonic_code),
		.illegal(illegal)
	);

	always #4 clk = ~clk;

	function automatic decode_result_t decode_instruction(input logic [31:0] w);
		decode_result_t r;
		logic [4:0]     mn;
		logic           ok;
		r = '0;
		mn = MN_ADD;
		ok = 1'b0;
		r.major_opcode = w[6:0];
		case (w[6:0])
			OPC_OP: begin
				r.format_code = FMT_R;
				r.dest_reg = w[11:7];
				r.src1_reg = w[19:15];
				r.src2_reg = w[24:20];
				r.func3_field = w[14:12];
				r.func7_field = w[31:25];
				ok = 1'b1;
				if (w[31:25] == F7_BASE) begin
					case (w[14:12])
						F3_ADD: mn = MN_ADD;
						F3_SLL: mn = MN_SLL;
						F3_XOR: mn = MN_XOR;
						F3_SR:  mn = MN_SRL;
						F3_OR:  mn = MN_OR;
						F3_AND: mn = MN_AND;
						default: ok = 1'b0;
					endcase
				end else if (w[31:25] == F7_ALT && w[14:12] == F3_ADD) begin
					mn = MN_SUB;
				end else if (w[31:25] == F7_ALT && w[14:12] == F3_SR) begin
					mn = MN_SRA;
				end else begin
					ok = 1'b0;
				end
			end
			OPC_OPIMM, OPC_LOAD: begin
				r.format_code = FMT_I;
				r.dest_reg = w[11:7];
				r.src1_reg = w[19:15];
				r.func3_field = w[14:12];
				r.immediate = {1'b0, w[31:20]};
				ok = 1'b1;
				if (w[6:0] == OPC_LOAD) begin
					mn = MN_LW;
					ok = (w[14:12] == F3_WORD);
				end else begin
					if (w[14:12] == F3_SLL || w[14:12] == F3_SR)
						r.func7_field = w[31:25];
					case (w[14:12])
						F3_ADD: mn = MN_ADDI;
						F3_XOR: mn = MN_XORI;
						F3_OR:  mn = MN_ORI;
						F3_AND: mn = MN_ANDI;
						F3_SLL: begin
							mn = MN_SLLI;
							ok = (w[31:25] == F7_BASE);
						end
						F3_SR: begin
							if (w[31:25] == F7_BASE)
								mn = MN_SRLI;
							else if (w[31:25] == F7_ALT)
								mn = MN_SRAI;
							else
								ok = 1'b0;
						end
						default: ok = 1'b0;
					endcase
				end
			end
			OPC_STORE: begin
				r.format_code = FMT_S;
				r.src1_reg = w[19:15];
				r.src2_reg = w[24:20];
				r.func3_field = w[14:12];
				r.immediate = {1'b0, w[31:25], w[11:7]};
				mn = MN_SW;
				ok = (w[14:12] == F3_WORD);
			end
			OPC_BRANCH: begin
				r.format_code = FMT_B;
				r.src1_reg = w[19:15];
				r.src2_reg = w[24:20];
				r.func3_field = w[14:12];
				r.immediate = {w[31], w[7], w[30:25], w[11:8], 1'b0};
				mn = MN_BEQ;
				ok = (w[14:12] == F3_ADD);
			end
			default: ok = 1'b0;
		endcase
		r.mnemonic_code = ok ? mn : MN_ADD;
		r.illegal = ~ok;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic send_instruction(input logic [31:0] w, input decode_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			instr_valid <= 1'b0;
			@(negedge clk);
		end
		instruction_word <= w;
		pending_decode <= want;
		instr_valid <= 1'b1;
		do @(posedge clk); while (!instr_ready);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		decode_result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_decodes.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual opcode %h",
						$time, major_opcode);
				end else begin
					want = expected_decodes.pop_front();
					compare_field("major_opcode", 32'(want.major_opcode),
						32'(major_opcode));
					compare_field("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
					compare_field("src1_reg", 32'(want.src1_reg), 32'(src1_reg));
					compare_field("src2_reg", 32'(want.src2_reg), 32'(src2_reg));
					compare_field("func3_field", 32'(want.func3_field),
						32'(func3_field));
					compare_field("func7_field", 32'(want.func7_field),
						32'(func7_field));
					compare_field("immediate", 32'(want.immediate), 32'(immediate));
					compare_field("format_code", 32'(want.format_code),
						32'(format_code));
					compare_field("mnemonic_code", 32'(want.mnemonic_code),
						32'(mnemonic_code));
					compare_field("illegal", 32'(want.illegal), 32'(illegal));
				end
			end
			if (instr_valid && instr_ready)
				expected_decodes.push_back(pending_decode);
			if ((instr_valid && instr_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 5000) begin
				$display("%0t: watchdog expired with %0d results outstanding",
					$time, expected_decodes.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] w;
		logic [6:0]  opc;
		stim_row_t   row;
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instruction_word = '0;
		result_ready = 1'b0;
		pending_decode = '0;

		stim_table.push_back({32'h0000_0000, 1'b1, {7'h00, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
			13'd0, FMT_R, MN_ADD, 1'b1}});
		stim_table.push_back({32'hFFFF_FFFF, 1'b1, {7'h7F, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
			13'd0, FMT_R, MN_ADD, 1'b1}});
		stim_table.push_back({32'hFFFF_FFB3, 1'b1, {OPC_OP, 5'h1F, 5'h1F, 5'h1F, F3_AND,
			7'h7F, 13'd0, FMT_R, MN_ADD, 1'b1}});
		stim_table.push_back({32'h0000_0013, 1'b1, {OPC_OPIMM, 5'd0, 5'd0, 5'd0, F3_ADD,
			F7_BASE, 13'd0, FMT_I, MN_ADDI, 1'b0}});
		stim_table.push_back({{F7_BASE, 5'd31, 5'd1, F3_ADD, 5'd2, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_ALT, 5'd3, 5'd31, F3_ADD, 5'd31, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd4, 5'd5, F3_XOR, 5'd6, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd7, 5'd8, F3_OR, 5'd9, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd10, 5'd11, F3_AND, 5'd12, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd13, 5'd14, F3_SLL, 5'd15, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd16, 5'd17, F3_SR, 5'd18, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{F7_ALT, 5'd19, 5'd20, F3_SR, 5'd21, OPC_OP}, 1'b0, 53'd0});
		stim_table.push_back({{12'hFFF, 5'd5, F3_ADD, 5'd6, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{12'h800, 5'd22, F3_XOR, 5'd23, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{12'h7FF, 5'd24, F3_OR, 5'd25, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{12'h001, 5'd26, F3_AND, 5'd27, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd31, 5'd7, F3_SLL, 5'd8, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{F7_BASE, 5'd1, 5'd2, F3_SR, 5'd3, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{F7_ALT, 5'd31, 5'd4, F3_SR, 5'd5, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{F7_ALT, 5'd2, 5'd6, F3_SLL, 5'd7, OPC_OPIMM}, 1'b0, 53'd0});
		stim_table.push_back({{12'hFFF, 5'd31, F3_WORD, 5'd31, OPC_LOAD}, 1'b0, 53'd0});
		stim_table.push_back({{12'h123, 5'd9, F3_ADD, 5'd10, OPC_LOAD}, 1'b0, 53'd0});
		stim_table.push_back({{7'h7F, 5'd1, 5'd2, F3_WORD, 5'h1F, OPC_STORE}, 1'b0, 53'd0});
		stim_table.push_back({{7'h7F, 5'd31, 5'd30, F3_ADD, 5'h1F, OPC_BRANCH}, 1'b0, 53'd0});
		stim_table.push_back({{7'h40, 5'd3, 5'd4, F3_SLL, 5'h01, OPC_BRANCH}, 1'b0, 53'd0});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			row = stim_table[i];
			send_instruction(row.word, row.typed ? row.golden : decode_instruction(row.word));
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			for (int n = 0; n < 125; n++) begin
				w = $urandom();
				if ($urandom_range(99) < 80) begin
					case ($urandom_range(4))
						0: opc = OPC_OP;
						1: opc = OPC_OPIMM;
						2: opc = OPC_LOAD;
						3: opc = OPC_STORE;
						default: opc = OPC_BRANCH;
					endcase
					w[6:0] = opc;
					if ($urandom_range(99) < 75)
						w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
					if ($urandom_range(99) < 60) begin
						if (opc == OPC_LOAD || opc == OPC_STORE)
							w[14:12] = F3_WORD;
						else if (opc == OPC_BRANCH)
							w[14:12] = F3_ADD;
					end
				end
				send_instruction(w, decode_instruction(w));
			end
			if (phase == 1) begin
				// hold the sender until the pipeline drains
				instr_valid <= 1'b0;
				wait (expected_decodes.size() == 0);
				@(negedge clk);
			end
		end
		instr_valid <= 1'b0;

		wait (expected_decodes.size() == 0);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
sv/rvdec_pkg.sv
sv/rvdec_decode.sv
sv/rv32i_subset_instruction_decoder_core.sv
bench/rv32i_subset_instruction_decoder_core_tb.sv
